// File: rtl/core/kdeb_pkg.sv
package kdeb_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_KEY    = 3'd0,
        REQ_POP    = 3'd1,
        REQ_NUMBER = 3'd2,
        REQ_FLAG   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    localparam int           NUM_FLAGS     = 6;
    localparam int           FLAG_ENTER    = 0;
    localparam int           CODE_W        = 8;
    localparam int           VALUE_W       = 30;
    localparam int           CNT_W         = 4;
    localparam int           SEL_W         = 3;
    localparam int           ADDR_W        = 5;
    localparam int           DATA_W        = 32;
    localparam logic [3:0]   MAX_DIGITS    = 4'd9;
    localparam logic [7:0]   CODE_RST_BASE = 8'd10;

    // control from the sequencer to the decimal accumulator
    typedef struct packed {
        logic clr;
        logic step;
    } t_acc_ctrl;

endpackage

// File: rtl/core/kdeb_req_if.sv
interface kdeb_req_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    req_type;
    logic [kdeb_pkg::CODE_W-1:0]   key_code;
    logic [kdeb_pkg::CNT_W-1:0]    digit_count;
    logic [kdeb_pkg::SEL_W-1:0]    flag_select;

    modport source (output valid, req_type, key_code, digit_count, flag_select,
                    input ready);
    modport sink   (input valid, req_type, key_code, digit_count, flag_select,
                    output ready);
endinterface

// File: rtl/core/kdeb_rsp_if.sv
interface kdeb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          success;
    logic [kdeb_pkg::VALUE_W-1:0]  value;

    modport source (output valid, success, value, input ready);
    modport sink   (input valid, success, value, output ready);
endinterface

// File: rtl/core/kdeb_accum.sv
// Decimal accumulator: acc = acc * 10 + digit, kept modulo 2^VALUE_W
module kdeb_accum (
    input  logic                          i_clk,
    input  kdeb_pkg::t_acc_ctrl           i_ctrl,
    input  logic [kdeb_pkg::CODE_W-1:0]   i_digit,
    output logic [kdeb_pkg::VALUE_W-1:0]  o_acc
);

    logic [kdeb_pkg::VALUE_W-1:0] r_acc;
    logic [kdeb_pkg::VALUE_W-1:0] n_acc;

    // times ten as two shifts and an add; upper bits fall off
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clr) begin
            n_acc = '0;
        end else if (i_ctrl.step) begin
            n_acc = (r_acc << 3) + (r_acc << 1)
                  + kdeb_pkg::VALUE_W'(i_digit);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/core/keypad_digit_entry_buffer.sv
// Channel   Dir  Handshake            Word
// i_req     in   valid/ready          req_type, key_code, digit_count, flag_select
// o_rsp     out  valid/ready          success, value
// apb       in   psel/penable/pwrite  six 8-bit key code registers, byte addr 4*i
//
// One request at a time: key event, flag, clear, empty pop, failed take number and take
// number of 0 digits go straight to S_EMIT; pop passes S_POP for the digit memory read;
// take number of N, 1 to 9, does one memory read per digit into the accumulator (S_ASM).
// A new request is taken while a word still waits in the output register; the
// sequencer then holds in its emit cycle until that word leaves.
// Synchronous active-low reset clears pointers, count and flags, reloads key codes.
module keypad_digit_entry_buffer #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kdeb_req_if.sink                       i_req,
    kdeb_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kdeb_pkg::ADDR_W-1:0]    paddr,
    input  logic [kdeb_pkg::DATA_W-1:0]    pwdata,
    output logic [kdeb_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int NW = (PW > kdeb_pkg::CNT_W) ? PW : kdeb_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POP  = 6'b000010,
        S_ASM  = 6'b000100,
        S_FIN  = 6'b001000,
        S_EMIT = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // configuration registers
    logic [kdeb_pkg::CODE_W-1:0] r_codes [kdeb_pkg::NUM_FLAGS];
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kdeb_pkg::NUM_FLAGS; i++) begin
                r_codes[i] <= kdeb_pkg::CODE_RST_BASE + 8'(i);
            end
        end else if (cfg_wr) begin
            for (int i = 0; i < kdeb_pkg::NUM_FLAGS; i++) begin
                if (cfg_idx == 3'(i)) begin
                    r_codes[i] <= pwdata[kdeb_pkg::CODE_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < kdeb_pkg::NUM_FLAGS; i++) begin
            if (cfg_idx == 3'(i)) begin
                prdata = kdeb_pkg::DATA_W'(r_codes[i]);
            end
        end
    end

    // sequencer state
    t_state                         r_state, n_state;
    logic [PW-1:0]                  r_wr_pos, n_wr_pos;
    logic [PW-1:0]                  r_rd_pos, n_rd_pos;
    logic [PW-1:0]                  r_held, n_held;
    logic [kdeb_pkg::NUM_FLAGS-1:0] r_flags, n_flags;
    logic [PW-1:0]                  r_addr, n_addr;
    logic [3:0]                     r_left, n_left;
    logic                           r_pend_ok, n_pend_ok;
    logic [kdeb_pkg::VALUE_W-1:0]   r_pend_val, n_pend_val;
    logic                           r_out_valid;
    logic                           r_out_ok;
    logic [kdeb_pkg::VALUE_W-1:0]   r_out_val;
    logic [kdeb_pkg::CODE_W-1:0]    r_rdata;

    // digit memory, registered read
    logic [kdeb_pkg::CODE_W-1:0]    mem [BUFFER_DEPTH];
    logic                           mem_we;
    logic                           rd_en;
    logic [PW-1:0]                  rd_addr;

    logic                           req_fire;
    logic                           out_free;
    logic                           out_load;
    kdeb_pkg::t_acc_ctrl            acc_ctrl;
    logic [kdeb_pkg::VALUE_W-1:0]   acc;

    // key match, first register in list order wins
    logic                           key_hit;
    logic [kdeb_pkg::NUM_FLAGS-1:0] hit_mask;
    // take-number helpers
    logic [3:0]                     n_sat;
    logic                           too_few;
    logic [NW-1:0]                  skip_w;
    logic [PW:0]                    start_sum;
    logic [PW-1:0]                  start_pos;
    logic [7:0]                     flags_ext;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    always_comb begin
        key_hit  = 1'b0;
        hit_mask = '0;
        for (int i = kdeb_pkg::NUM_FLAGS - 1; i >= 0; i--) begin
            if (r_codes[i] == i_req.key_code) begin
                key_hit  = 1'b1;
                hit_mask = kdeb_pkg::NUM_FLAGS'(1) << i;
            end
        end
    end

    assign n_sat     = (i_req.digit_count > kdeb_pkg::MAX_DIGITS) ?
                       kdeb_pkg::MAX_DIGITS : i_req.digit_count;
    assign too_few   = NW'(r_held) < NW'(n_sat);
    assign skip_w    = NW'(r_held) - NW'(n_sat);
    assign start_sum = {1'b0, r_rd_pos} + {1'b0, skip_w[PW-1:0]};
    assign start_pos = (start_sum >= (PW + 1)'(BUFFER_DEPTH)) ?
                       PW'(start_sum - (PW + 1)'(BUFFER_DEPTH)) : start_sum[PW-1:0];
    assign flags_ext = 8'(r_flags);

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_wr_pos   = r_wr_pos;
        n_rd_pos   = r_rd_pos;
        n_held     = r_held;
        n_flags    = r_flags;
        n_addr     = r_addr;
        n_left     = r_left;
        n_pend_ok  = r_pend_ok;
        n_pend_val = r_pend_val;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_rd_pos;
        acc_ctrl   = '0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_pend_ok  = 1'b0;
                    n_pend_val = '0;
                    n_state    = S_EMIT;
                    case (i_req.req_type)
                        kdeb_pkg::REQ_KEY: begin
                            if (key_hit) begin
                                n_flags = r_flags | hit_mask;
                            end else if (r_held < PW'(BUFFER_DEPTH - 1)) begin
                                mem_we   = 1'b1;
                                n_wr_pos = f_next(r_wr_pos);
                                n_held   = r_held + 1'b1;
                            end
                        end
                        kdeb_pkg::REQ_POP: begin
                            if (r_held != '0) begin
                                rd_en    = 1'b1;
                                n_rd_pos = f_next(r_rd_pos);
                                n_held   = r_held - 1'b1;
                                n_state  = S_POP;
                            end
                        end
                        kdeb_pkg::REQ_NUMBER: begin
                            if (r_flags[kdeb_pkg::FLAG_ENTER]) begin
                                n_flags  = '0;
                                n_wr_pos = '0;
                                n_rd_pos = '0;
                                n_held   = '0;
                                if (!too_few) begin
                                    n_pend_ok    = 1'b1;
                                    acc_ctrl.clr = 1'b1;
                                    if (n_sat != '0) begin
                                        rd_en   = 1'b1;
                                        rd_addr = start_pos;
                                        n_addr  = f_next(start_pos);
                                        n_left  = n_sat;
                                        n_state = S_ASM;
                                    end
                                end
                            end
                        end
                        kdeb_pkg::REQ_FLAG: begin
                            if (i_req.flag_select < kdeb_pkg::SEL_W'(kdeb_pkg::NUM_FLAGS)
                                && flags_ext[i_req.flag_select]) begin
                                n_flags   = r_flags & ~(kdeb_pkg::NUM_FLAGS'(1)
                                                        << i_req.flag_select);
                                n_pend_ok = 1'b1;
                            end
                        end
                        kdeb_pkg::REQ_CLEAR: begin
                            n_flags  = '0;
                            n_wr_pos = '0;
                            n_rd_pos = '0;
                            n_held   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_pend_ok  = 1'b1;
                n_pend_val = kdeb_pkg::VALUE_W'(r_rdata);
                n_state    = S_EMIT;
            end
            S_ASM: begin
                // fold in the digit read last cycle, fetch the next one while digits remain
                acc_ctrl.step = 1'b1;
                n_left        = r_left - 1'b1;
                if (r_left == 4'd1) begin
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr;
                    n_addr  = f_next(r_addr);
                end
            end
            S_FIN: begin
                n_pend_val = acc;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_held      <= '0;
            r_flags     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_held   <= n_held;
            r_flags  <= n_flags;
            r_left   <= n_left;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pend_ok  <= n_pend_ok;
        r_pend_val <= n_pend_val;
        if (out_load) begin
            r_out_ok  <= r_pend_ok;
            r_out_val <= r_pend_val;
        end
    end

    // digit memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_pos] <= i_req.key_code;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    kdeb_accum u_accum (
        .i_clk   (i_clk),
        .i_ctrl  (acc_ctrl),
        .i_digit (r_rdata),
        .o_acc   (acc)
    );

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.success = r_out_ok;
    assign o_rsp.value   = r_out_val;

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != S_IDLE))
        else $error("sequencer idle right after a request was taken");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= PW'(BUFFER_DEPTH - 1))
        else $error("held count above buffer capacity");

    a_asm_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASM) |-> (r_left != '0) && (r_left <= kdeb_pkg::MAX_DIGITS))
        else $error("digit counter out of range while assembling");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.req_type == kdeb_pkg::REQ_CLEAR)
        |=> (r_held == '0) && (r_flags == '0) && (r_rd_pos == '0))
        else $error("clear request left state behind");

endmodule
